[rtl/bpba_pkg.sv]
// shared types, codes and constants of the bitmap page block allocator
`default_nettype none
package bpba_pkg;

  localparam int PAGE_BLOCKS_MAX_DEF = 1024;

  localparam int OP_W    = 2;
  localparam int BYTES_W = 31;
  localparam int IDX_W   = 10;
  localparam int ST_W    = 2;
  localparam int LEN_W   = 8;
  localparam int PB_W    = 11;
  localparam int SHIFT_W = 5;
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 2;
  localparam int SP_W    = 11;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_START = 2'd3;

  localparam logic [CFG_IW-1:0] REG_PAGE_BLOCKS  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FIRST_USABLE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BLOCK_SHIFT  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_FIXED_MODE   = 2'd3;

  localparam logic [PB_W-1:0]    PAGE_BLOCKS_RST = 11'd1024;
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd3;
  localparam logic [SP_W-1:0]    SP_SAT          = 11'h7FF;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR_ALL,
    CMD_CLR_MARK,
    CMD_LOAD,
    CMD_SIZE,
    CMD_MARK,
    CMD_QUERY,
    CMD_BEGIN,
    CMD_FAIL,
    CMD_FAIL_SP,
    CMD_BAD,
    CMD_STEP,
    CMD_SKIP,
    CMD_FREE,
    CMD_ZERO,
    CMD_GRANT
  } cmd_t;

  // second grant flavor is selected by fixed mode inside the datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic fixed;
    logic sweep;
    logic bad_size;
    logic pos_ge_end;
    logic pos_n_gt_end;
    logic marked;
    logic avail_hit;
    logic k_last;
    logic clr_last;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/bpba_datapath.sv]
// datapath: config registers, mark and length memories, scan pointer and result registers
`default_nettype none
module bpba_datapath #(
  parameter int PAGE_BLOCKS_MAX = bpba_pkg::PAGE_BLOCKS_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bpba_pkg::cmd_t              cmd,
  output bpba_pkg::dp_status_t             stat,
  input  wire logic [bpba_pkg::OP_W-1:0]    in_operation,
  input  wire logic [bpba_pkg::BYTES_W-1:0] in_request_bytes,
  input  wire logic [bpba_pkg::IDX_W-1:0]   in_block_index,
  input  wire logic                        cfg_we,
  input  wire logic [bpba_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [bpba_pkg::CFG_W-1:0]   cfg_data,
  output logic                             out_valid,
  output logic [bpba_pkg::ST_W-1:0]         out_status,
  output logic [bpba_pkg::IDX_W-1:0]        out_granted_index,
  output logic [bpba_pkg::LEN_W-1:0]        out_run_length,
  output logic                             out_is_marked
);
  import bpba_pkg::*;

  localparam int AW = $clog2(PAGE_BLOCKS_MAX);
  localparam int PW = (AW > 12) ? AW : 12;
  localparam logic [AW-1:0] CLR_LAST = AW'(PAGE_BLOCKS_MAX - 1);

  logic [PB_W-1:0]    page_blocks_r;
  logic [IDX_W-1:0]   first_usable_r;
  logic [SHIFT_W-1:0] block_shift_r;
  logic               fixed_mode_r;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic               sweep_r, sweep_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [OP_W-1:0]    op_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [IDX_W-1:0]   idx_r;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [LEN_W-1:0]   n_r, avail_r, k_r;
  logic               bad_r;
  logic               ov_r;
  logic [ST_W-1:0]    ost_r;
  logic [IDX_W-1:0]   oidx_r;
  logic [LEN_W-1:0]   olen_r;
  logic               omk_r;

  logic               mark_mem [PAGE_BLOCKS_MAX];
  logic [LEN_W-1:0]   len_mem [PAGE_BLOCKS_MAX];
  logic               mark_q_r;
  logic [LEN_W-1:0]   len_q_r;
  logic               mark_we, mark_wd, len_we;
  logic [AW-1:0]      mark_wa, len_wa;
  logic [LEN_W-1:0]   len_wd;

  logic [PB_W-1:0]    end_w;
  logic [SP_W-1:0]    start_w;
  logic [31:0]        mask_w, cnt_w;
  logic               in_range;
  logic [PW-1:0]      pos_k;
  logic [PW-1:0]      pos_n;
  logic [SP_W-1:0]    sat_pos, sat_pos1, sat_posn;

  always_comb begin
    end_w    = (32'(page_blocks_r) < PAGE_BLOCKS_MAX) ? page_blocks_r : PB_W'(PAGE_BLOCKS_MAX);
    start_w  = (sp_r > SP_W'(first_usable_r)) ? sp_r : SP_W'(first_usable_r);
    mask_w   = (32'd1 << block_shift_r) - 32'd1;
    cnt_w    = ({1'b0, bytes_r} + mask_w) >> block_shift_r;
    in_range = 32'(idx_r) < PAGE_BLOCKS_MAX;
    pos_k    = pos_r + PW'(k_r);
    pos_n    = pos_r + PW'(n_r);
    sat_pos  = (pos_r > PW'(SP_SAT)) ? SP_SAT : pos_r[SP_W-1:0];
    sat_pos1 = (pos_r + PW'(1) > PW'(SP_SAT)) ? SP_SAT : SP_W'(pos_r + PW'(1));
    sat_posn = (pos_n > PW'(SP_SAT)) ? SP_SAT : pos_n[SP_W-1:0];
  end

  always_comb begin
    stat.op           = op_r;
    stat.fixed        = fixed_mode_r;
    stat.sweep        = sweep_r;
    stat.bad_size     = bad_r;
    stat.pos_ge_end   = pos_r >= PW'(end_w);
    stat.pos_n_gt_end = ({1'b0, pos_r} + (PW+1)'(n_r)) > (PW+1)'(end_w);
    stat.marked       = mark_q_r;
    stat.avail_hit    = ({1'b0, avail_r} + 9'd1) >= {1'b0, n_r};
    stat.k_last       = k_r == (n_r - LEN_W'(1));
    stat.clr_last     = clr_r == CLR_LAST;
  end

  // memory write port selection
  always_comb begin
    mark_we = 1'b0;
    mark_wa = clr_r;
    mark_wd = 1'b0;
    len_we  = 1'b0;
    len_wa  = clr_r;
    len_wd  = '0;
    case (cmd)
      CMD_CLR_ALL: begin
        mark_we = 1'b1;
        len_we  = 1'b1;
      end
      CMD_CLR_MARK: mark_we = 1'b1;
      CMD_MARK: begin
        mark_we = in_range;
        mark_wa = pos_r[AW-1:0];
        mark_wd = 1'b1;
      end
      CMD_ZERO: begin
        len_we = 1'b1;
        len_wa = pos_k[AW-1:0];
      end
      CMD_GRANT: begin
        len_we  = ~fixed_mode_r;
        len_wa  = pos_r[AW-1:0];
        len_wd  = n_r;
        mark_we = ~fixed_mode_r & sweep_r;
        mark_wa = pos_r[AW-1:0];
        mark_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (len_we) len_mem[len_wa] <= len_wd;
    mark_q_r <= mark_mem[pos_r[AW-1:0]];
    len_q_r  <= len_mem[pos_r[AW-1:0]];
  end

  always_comb begin
    sp_nxt    = sp_r;
    sweep_nxt = sweep_r;
    clr_nxt   = clr_r;
    pos_nxt   = pos_r;
    case (cmd)
      CMD_CLR_ALL, CMD_CLR_MARK: clr_nxt = clr_r + AW'(1);
      CMD_LOAD:
        pos_nxt = (in_operation == OP_ALLOC) ? PW'(start_w) : PW'(in_block_index);
      CMD_BEGIN: begin
        sweep_nxt = 1'b1;
        sp_nxt    = SP_W'(first_usable_r);
        clr_nxt   = '0;
      end
      CMD_FAIL_SP: sp_nxt = sat_pos;
      CMD_STEP:    pos_nxt = pos_r + PW'(1);
      CMD_SKIP:    pos_nxt = pos_r + ((len_q_r == '0) ? PW'(1) : PW'(len_q_r));
      CMD_FREE:
        pos_nxt = stat.avail_hit ? pos_r + PW'(1) - PW'(n_r) : pos_r + PW'(1);
      CMD_GRANT:   sp_nxt = fixed_mode_r ? sat_pos1 : sat_posn;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_blocks_r  <= PAGE_BLOCKS_RST;
      first_usable_r <= '0;
      block_shift_r  <= BLOCK_SHIFT_RST;
      fixed_mode_r   <= 1'b0;
      sp_r           <= '0;
      sweep_r        <= 1'b0;
      clr_r          <= '0;
      ov_r           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAGE_BLOCKS:  page_blocks_r  <= cfg_data[PB_W-1:0];
          REG_FIRST_USABLE: first_usable_r <= cfg_data[IDX_W-1:0];
          REG_BLOCK_SHIFT:  block_shift_r  <= cfg_data[SHIFT_W-1:0];
          REG_FIXED_MODE:   fixed_mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
      sp_r    <= sp_nxt;
      sweep_r <= sweep_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= (cmd == CMD_MARK) || (cmd == CMD_QUERY) || (cmd == CMD_BEGIN) ||
                 (cmd == CMD_FAIL) || (cmd == CMD_FAIL_SP) || (cmd == CMD_BAD) ||
                 (cmd == CMD_GRANT);
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    case (cmd)
      CMD_LOAD: begin
        op_r    <= in_operation;
        bytes_r <= in_request_bytes;
        idx_r   <= in_block_index;
        avail_r <= '0;
        k_r     <= '0;
      end
      CMD_SIZE: begin
        bad_r <= (cnt_w == 32'd0) || (cnt_w > 32'd255);
        n_r   <= cnt_w[LEN_W-1:0];
      end
      CMD_SKIP: avail_r <= '0;
      CMD_FREE: avail_r <= avail_r + LEN_W'(1);
      CMD_ZERO: k_r <= k_r + LEN_W'(1);
      CMD_MARK: begin
        ost_r  <= ST_OK;
        oidx_r <= idx_r;
        olen_r <= in_range ? len_q_r : '0;
        omk_r  <= 1'b1;
      end
      CMD_QUERY: begin
        oidx_r <= idx_r;
        if (!stat.pos_ge_end && fixed_mode_r) begin
          ost_r  <= ST_OK;
          olen_r <= LEN_W'(1);
          omk_r  <= mark_q_r;
        end else if (!stat.pos_ge_end) begin
          ost_r  <= (len_q_r != '0) ? ST_OK : ST_NO_START;
          olen_r <= len_q_r;
          omk_r  <= mark_q_r;
        end else begin
          ost_r  <= ST_NO_START;
          olen_r <= '0;
          omk_r  <= 1'b0;
        end
      end
      CMD_BEGIN: begin
        ost_r  <= ST_OK;
        oidx_r <= first_usable_r;
        olen_r <= '0;
        omk_r  <= 1'b0;
      end
      CMD_FAIL, CMD_FAIL_SP, CMD_BAD: begin
        ost_r  <= (cmd == CMD_BAD) ? ST_BAD_SIZE : ST_NO_ROOM;
        oidx_r <= '0;
        olen_r <= '0;
        omk_r  <= 1'b0;
      end
      CMD_GRANT: begin
        ost_r  <= ST_OK;
        oidx_r <= pos_r[IDX_W-1:0];
        olen_r <= fixed_mode_r ? LEN_W'(1) : n_r;
        omk_r  <= ~fixed_mode_r & sweep_r;
      end
      default: ;
    endcase
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_granted_index = oidx_r;
  assign out_run_length    = olen_r;
  assign out_is_marked     = omk_r;

endmodule
`default_nettype wire

[rtl/bpba_ctrl.sv]
// controller: sequences clearing passes, decode, bitmap scan and length table writes
`default_nettype none
module bpba_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bpba_pkg::dp_status_t stat,
  output bpba_pkg::cmd_t            cmd
);
  import bpba_pkg::*;

  localparam logic [3:0] S_RST_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WAIT1    = 4'd2;
  localparam logic [3:0] S_DISPATCH = 4'd3;
  localparam logic [3:0] S_FWAIT    = 4'd4;
  localparam logic [3:0] S_VEVAL    = 4'd5;
  localparam logic [3:0] S_VCHK     = 4'd6;
  localparam logic [3:0] S_VWAIT    = 4'd7;
  localparam logic [3:0] S_ZERO     = 4'd8;
  localparam logic [3:0] S_FINAL    = 4'd9;
  localparam logic [3:0] S_CLR_MARK = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_RST_CLR: begin
        cmd = CMD_CLR_ALL;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_WAIT1;
        end
      end
      S_WAIT1: begin
        cmd       = CMD_SIZE;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_MARK: begin
            cmd       = CMD_MARK;
            state_nxt = S_IDLE;
          end
          OP_SWEEP: begin
            cmd       = CMD_BEGIN;
            state_nxt = S_CLR_MARK;
          end
          OP_QUERY: begin
            cmd       = CMD_QUERY;
            state_nxt = S_IDLE;
          end
          default: begin
            if (stat.fixed) begin
              // fixed mode walks marked blocks one at a time
              if (stat.sweep && !stat.pos_ge_end && stat.marked) begin
                cmd       = CMD_STEP;
                state_nxt = S_FWAIT;
              end else if (stat.pos_ge_end) begin
                cmd       = CMD_FAIL_SP;
                state_nxt = S_IDLE;
              end else begin
                cmd       = CMD_GRANT;
                state_nxt = S_IDLE;
              end
            end else if (stat.bad_size) begin
              cmd       = CMD_BAD;
              state_nxt = S_IDLE;
            end else if (stat.pos_n_gt_end) begin
              cmd       = CMD_FAIL;
              state_nxt = S_IDLE;
            end else if (!stat.sweep) begin
              state_nxt = S_ZERO;
            end else begin
              state_nxt = S_VEVAL;
            end
          end
        endcase
      end
      S_FWAIT: state_nxt = S_DISPATCH;
      S_VEVAL: begin
        if (stat.pos_ge_end) begin
          cmd       = CMD_FAIL_SP;
          state_nxt = S_IDLE;
        end else if (stat.marked) begin
          cmd       = CMD_SKIP;
          state_nxt = S_VCHK;
        end else begin
          cmd       = CMD_FREE;
          state_nxt = stat.avail_hit ? S_ZERO : S_VWAIT;
        end
      end
      S_VCHK: begin
        // a skipped run may leave no room for the request
        if (stat.pos_n_gt_end) begin
          cmd       = CMD_FAIL_SP;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_VEVAL;
        end
      end
      S_VWAIT: state_nxt = S_VEVAL;
      S_ZERO: begin
        cmd = CMD_ZERO;
        if (stat.k_last) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd       = CMD_GRANT;
        state_nxt = S_IDLE;
      end
      S_CLR_MARK: begin
        cmd = CMD_CLR_MARK;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_WAIT1))
    else $error("accepted request did not start decode");

  a_zero_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO && !stat.k_last) |=> (state_r == S_ZERO))
    else $error("length clear loop left early");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR_MARK || state_r == S_RST_CLR) |-> busy)
    else $error("request possible during clearing pass");

endmodule
`default_nettype wire

[rtl/bitmap_page_block_allocator.sv]
// top level: bitmap page block allocator with lazy sweep
// mark, query, begin sweep, bad size, early no room: result registered from the dispatch state
// begin sweep then stays busy while it clears the whole mark memory
// alloc grant: clears n length entries, then grants; a sweep scan first walks runs and free blocks
// fixed mode alloc: steps over marked blocks one at a time; single read port sets scan rate
// reset: clearing pass of both memories with busy high; results never stall
`default_nettype none
module bitmap_page_block_allocator #(
  parameter int PAGE_BLOCKS_MAX = bpba_pkg::PAGE_BLOCKS_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [bpba_pkg::OP_W-1:0]    in_operation,
  input  wire logic [bpba_pkg::BYTES_W-1:0] in_request_bytes,
  input  wire logic [bpba_pkg::IDX_W-1:0]   in_block_index,
  input  wire logic                        cfg_we,
  input  wire logic [bpba_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [bpba_pkg::CFG_W-1:0]   cfg_data,
  output logic                             out_valid,
  output logic [bpba_pkg::ST_W-1:0]         out_status,
  output logic [bpba_pkg::IDX_W-1:0]        out_granted_index,
  output logic [bpba_pkg::LEN_W-1:0]        out_run_length,
  output logic                             out_is_marked
);
  import bpba_pkg::*;

  cmd_t       cmd;
  dp_status_t stat;

  bpba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bpba_datapath #(
    .PAGE_BLOCKS_MAX (PAGE_BLOCKS_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_request_bytes  (in_request_bytes),
    .in_block_index    (in_block_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_run_length    (out_run_length),
    .out_is_marked     (out_is_marked)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule
`default_nettype wire
